@@ rtl/core/fspq_pkg.sv @@
// Package for the four-level stable priority queue: operation and status codes,
// level limits and the control word that the queue hands to every cell.
// Depends on nothing.
package fspq_pkg;

  localparam int unsigned MODE_BITS   = 2;
  localparam int unsigned LEVEL_BITS  = 3;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned OUT_TAG_BITS = 16;
  localparam int unsigned OCC_BITS    = 7;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned DEF_TAG_BITS = 16;

  localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_PEEK   = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  localparam logic [LEVEL_BITS-1:0] LEVEL_BREAKING = 3'd1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_LOCAL    = 3'd4;

  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic [LEVEL_BITS-1:0] level;
  } fspq_ctl_t;

endpackage

@@ rtl/core/fspq_cell.sv @@
// One slot of the priority queue chain: holds a level and a tag and takes
// a new word, its left neighbour's word or its right neighbour's word.
// Depends on fspq_pkg.
module fspq_cell #(
  parameter int unsigned TAG_BITS = fspq_pkg::DEF_TAG_BITS
) (
  input  logic                            clk,
  input  fspq_pkg::fspq_ctl_t             ctl,
  input  logic [TAG_BITS-1:0]             new_tag,
  input  logic                            occupied,
  input  logic                            prev_keep,
  input  logic [fspq_pkg::LEVEL_BITS-1:0] prv_level,
  input  logic [TAG_BITS-1:0]             prv_tag,
  input  logic [fspq_pkg::LEVEL_BITS-1:0] nxt_level,
  input  logic [TAG_BITS-1:0]             nxt_tag,
  output logic                            keep,
  output logic [fspq_pkg::LEVEL_BITS-1:0] level,
  output logic [TAG_BITS-1:0]             tag
);
  import fspq_pkg::*;

  logic [LEVEL_BITS-1:0] level_r, level_nxt;
  logic [TAG_BITS-1:0]   tag_r, tag_nxt;

  // An occupied slot whose entry is at least as urgent as the new one stays put.
  assign keep = occupied && (level_r <= ctl.level);

  always_comb begin
    level_nxt = level_r;
    tag_nxt   = tag_r;
    if (ctl.ins && !keep) begin
      if (prev_keep) begin
        level_nxt = ctl.level;
        tag_nxt   = new_tag;
      end else begin
        level_nxt = prv_level;
        tag_nxt   = prv_tag;
      end
    end else if (ctl.rem) begin
      level_nxt = nxt_level;
      tag_nxt   = nxt_tag;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    tag_r   <= tag_nxt;
  end

  assign level = level_r;
  assign tag   = tag_r;

endmodule

@@ rtl/core/four_level_stable_priority_queue.sv @@
// Top level of the four-level stable priority queue: command decode, entry
// count, result register and the chain of fspq_cell slots.
// Depends on fspq_pkg and fspq_cell.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+---------------------
//   input    | in_mode, in_level, in_tag               | start high, busy low
//   result   | out_status, out_head_valid, out_head_tag,| out_strobe, 1 cycle
//            | out_head_level, out_occupancy           |
//
// For every word, all slots shift or hold in parallel at the
// accepting edge, and the result appears on the following cycle.
// busy is always low, so a new word may follow in every cycle.
// Reset clears the entry count and the strobe; slot contents are not reset.
// The receiver cannot stall, so results are never held back.
module four_level_stable_priority_queue #(
  parameter int unsigned CAPACITY = fspq_pkg::DEF_CAPACITY,
  parameter int unsigned TAG_BITS = fspq_pkg::DEF_TAG_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [fspq_pkg::MODE_BITS-1:0]    in_mode,
  input  logic [fspq_pkg::LEVEL_BITS-1:0]   in_level,
  input  logic [fspq_pkg::OUT_TAG_BITS-1:0] in_tag,
  output logic                              out_strobe,
  output logic [fspq_pkg::STATUS_BITS-1:0]  out_status,
  output logic                              out_head_valid,
  output logic [fspq_pkg::OUT_TAG_BITS-1:0] out_head_tag,
  output logic [fspq_pkg::LEVEL_BITS-1:0]   out_head_level,
  output logic [fspq_pkg::OCC_BITS-1:0]     out_occupancy
);
  import fspq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]          count_r, count_nxt;
  logic                   strobe_r;
  logic [STATUS_BITS-1:0] status_r, status_nxt;
  logic                   full, empty;
  logic [LEVEL_BITS-1:0]  level_clamped;
  logic [TAG_BITS-1:0]    tag_in;
  fspq_ctl_t              ctl;

  logic [CAPACITY-1:0]   occ;
  logic [CAPACITY-1:0]   keep;
  logic [LEVEL_BITS-1:0] cell_level [CAPACITY];
  logic [TAG_BITS-1:0]   cell_tag   [CAPACITY];

  assign busy  = 1'b0;
  assign full  = (count_r >= CW'(CAPACITY));
  assign empty = (count_r == '0);

  assign level_clamped = ((in_level >= LEVEL_BREAKING) && (in_level <= LEVEL_LOCAL)) ?
                         in_level : LEVEL_LOCAL;

  generate
    if (TAG_BITS <= OUT_TAG_BITS) begin : g_tag_narrow
      assign tag_in       = in_tag[TAG_BITS-1:0];
      assign out_head_tag = out_head_valid ? OUT_TAG_BITS'(cell_tag[0]) : '0;
    end else begin : g_tag_wide
      assign tag_in       = {{(TAG_BITS - OUT_TAG_BITS){1'b0}}, in_tag};
      assign out_head_tag = out_head_valid ? cell_tag[0][OUT_TAG_BITS-1:0] : '0;
    end
    if (CW <= OCC_BITS) begin : g_occ_narrow
      assign out_occupancy = OCC_BITS'(count_r);
    end else begin : g_occ_wide
      assign out_occupancy = count_r[OCC_BITS-1:0];
    end
  endgenerate

  always_comb begin
    ctl.ins    = 1'b0;
    ctl.rem    = 1'b0;
    ctl.level  = level_clamped;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (start) begin
      unique case (in_mode)
        MODE_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_DONE;
            ctl.ins    = 1'b1;
            count_nxt  = count_r + CW'(1);
          end
        end
        MODE_REMOVE: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            status_nxt = ST_DONE;
            ctl.rem    = 1'b1;
            count_nxt  = count_r - CW'(1);
          end
        end
        default: begin
          status_nxt = empty ? ST_EMPTY : ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  prev_keep;
      logic [LEVEL_BITS-1:0] prv_level, nxt_level;
      logic [TAG_BITS-1:0]   prv_tag, nxt_tag;

      assign occ[i] = (count_r > CW'(i));

      if (i == 0) begin : g_first
        assign prev_keep = 1'b1;
        assign prv_level = level_clamped;
        assign prv_tag   = tag_in;
      end else begin : g_inner
        assign prev_keep = keep[i-1];
        assign prv_level = cell_level[i-1];
        assign prv_tag   = cell_tag[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign nxt_level = cell_level[i];
        assign nxt_tag   = cell_tag[i];
      end else begin : g_body
        assign nxt_level = cell_level[i+1];
        assign nxt_tag   = cell_tag[i+1];
      end

      fspq_cell #(
        .TAG_BITS (TAG_BITS)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .new_tag   (tag_in),
        .occupied  (occ[i]),
        .prev_keep (prev_keep),
        .prv_level (prv_level),
        .prv_tag   (prv_tag),
        .nxt_level (nxt_level),
        .nxt_tag   (nxt_tag),
        .keep      (keep[i]),
        .level     (cell_level[i]),
        .tag       (cell_tag[i])
      );
    end
  endgenerate

  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_head_valid = !empty;
  assign out_head_level = out_head_valid ? cell_level[0] : '0;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the four-level stable priority queue: a driver and a
// monitor around the block, checked against a behavioural copy of the queue.
// Depends on fspq_pkg and four_level_stable_priority_queue.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fspq_pkg::*;

  localparam int unsigned CAPACITY = DEF_CAPACITY;
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic [MODE_BITS-1:0]    mode;
    logic [LEVEL_BITS-1:0]   level;
    logic [OUT_TAG_BITS-1:0] tag;
  } cmd_word_t;

  typedef struct packed {
    logic [OUT_TAG_BITS-1:0] tag;
    logic [LEVEL_BITS-1:0]   level;
  } slot_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]  status;
    logic                    head_valid;
    logic [OUT_TAG_BITS-1:0] head_tag;
    logic [LEVEL_BITS-1:0]   head_level;
    logic [OCC_BITS-1:0]     occupancy;
  } head_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [MODE_BITS-1:0] in_mode = MODE_PEEK;
  logic [LEVEL_BITS-1:0] in_level = '0;
  logic [OUT_TAG_BITS-1:0] in_tag = '0;
  logic busy;
  logic out_strobe;
  logic [STATUS_BITS-1:0] out_status;
  logic out_head_valid;
  logic [OUT_TAG_BITS-1:0] out_head_tag;
  logic [LEVEL_BITS-1:0] out_head_level;
  logic [OCC_BITS-1:0] out_occupancy;

  cmd_word_t    cmd_backlog[$];
  head_report_t due_reports[$];
  slot_t        queue_slots[$];

  int idle_pct = 0;
  int gap_left = 0;
  int mismatches = 0;
  int words_taken = 0;
  int words_checked = 0;
  int full_drops = 0;
  int empty_hits = 0;
  int peak_fill = 0;
  int cycles = 0;

  four_level_stable_priority_queue dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_level(in_level), .in_tag(in_tag),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_head_valid(out_head_valid), .out_head_tag(out_head_tag),
    .out_head_level(out_head_level), .out_occupancy(out_occupancy)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one word to the queue copy and returns the report the block should give.
  function automatic head_report_t queue_step(cmd_word_t w);
    head_report_t r;
    slot_t s;
    int pos;
    logic [LEVEL_BITS-1:0] lv;
    lv = (w.level >= LEVEL_BREAKING && w.level <= LEVEL_LOCAL) ? w.level : LEVEL_LOCAL;
    r = '0;
    r.status = ST_DONE;
    case (w.mode)
      MODE_INSERT: begin
        if (queue_slots.size() >= CAPACITY) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          pos = 0;
          while (pos < queue_slots.size() && queue_slots[pos].level <= lv) pos++;
          s.tag = w.tag;
          s.level = lv;
          queue_slots.insert(pos, s);
        end
      end
      MODE_REMOVE: begin
        if (queue_slots.size() == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end else begin
          void'(queue_slots.pop_front());
        end
      end
      default: begin
        if (queue_slots.size() == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end
      end
    endcase
    if (queue_slots.size() > 0) begin
      r.head_valid = 1'b1;
      r.head_tag = queue_slots[0].tag;
      r.head_level = queue_slots[0].level;
    end
    r.occupancy = OCC_BITS'(queue_slots.size());
    if (queue_slots.size() > peak_fill) peak_fill = queue_slots.size();
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch in %s on word %0d: got %0h, want %0h",
               field, words_checked, got, want);
  endtask

  always @(posedge clk) begin
    cmd_word_t w;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() == 0) begin
        start <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        gap_left = $urandom_range(0, 12);
        start <= 1'b0;
      end else begin
        w = cmd_backlog.pop_front();
        in_mode <= w.mode;
        in_level <= w.level;
        in_tag <= w.tag;
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    head_report_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (due_reports.size() == 0) begin
          report_mismatch("strobe with nothing due", 16'd1, 16'd0);
        end else begin
          want = due_reports.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_head_valid !== want.head_valid)
            report_mismatch("head_valid", out_head_valid, want.head_valid);
          if (out_head_tag !== want.head_tag)
            report_mismatch("head_tag", out_head_tag, want.head_tag);
          if (out_head_level !== want.head_level)
            report_mismatch("head_level", out_head_level, want.head_level);
          if (out_occupancy !== want.occupancy)
            report_mismatch("occupancy", out_occupancy, want.occupancy);
          words_checked++;
        end
      end
      if (start && !busy) begin
        due_reports.push_back(queue_step({in_mode, in_level, in_tag}));
        words_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_word(logic [MODE_BITS-1:0] mode, logic [LEVEL_BITS-1:0] level,
                           logic [OUT_TAG_BITS-1:0] tag);
    cmd_backlog.push_back({mode, level, tag});
  endtask

  task automatic load_random(int count, int ins_pct, int rem_pct);
    int r;
    logic [MODE_BITS-1:0] mode;
    logic [LEVEL_BITS-1:0] level;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) mode = MODE_INSERT;
      else if (r < ins_pct + rem_pct) mode = MODE_REMOVE;
      else mode = ($urandom_range(0, 3) == 0) ? MODE_SPARE : MODE_PEEK;
      if ($urandom_range(0, 99) < 85) level = 3'($urandom_range(1, 4));
      else level = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
      push_word(mode, level, 16'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || start || due_reports.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    push_word(MODE_PEEK, 3'd0, 16'h0000);
    push_word(MODE_REMOVE, 3'd7, 16'hffff);
    push_word(MODE_SPARE, 3'd3, 16'h1234);
    push_word(MODE_INSERT, 3'd0, 16'h0000);
    push_word(MODE_INSERT, 3'd7, 16'hffff);
    push_word(MODE_INSERT, 3'd5, 16'h5a5a);
    push_word(MODE_INSERT, 3'd6, 16'ha5a5);
    push_word(MODE_INSERT, LEVEL_LOCAL, 16'h0004);
    push_word(MODE_INSERT, 3'd3, 16'h0003);
    push_word(MODE_INSERT, 3'd2, 16'h0002);
    push_word(MODE_INSERT, LEVEL_BREAKING, 16'h0001);
    push_word(MODE_INSERT, 3'd2, 16'h0022);
    push_word(MODE_INSERT, LEVEL_BREAKING, 16'h0011);
    push_word(MODE_PEEK, 3'd4, 16'hffff);
    push_word(MODE_SPARE, 3'd0, 16'h0000);
    for (int i = 0; i < 6; i++) push_word(MODE_REMOVE, 3'($urandom_range(0, 7)), 16'($urandom));
    push_word(MODE_PEEK, 3'd1, 16'h8000);
    wait_drained();

    idle_pct = 15;
    load_random(160, 80, 10);
    wait_drained();
    idle_pct = 0;
    load_random(150, 15, 75);
    wait_drained();
    idle_pct = 25;
    load_random(60, 50, 35);
    wait_drained();
    idle_pct = 0;
    load_random(80, 45, 40);
    wait_drained();
    repeat (4) @(posedge clk);

    $display("Ran %0d words, checked %0d reports, peak fill %0d of %0d.",
             words_taken, words_checked, peak_fill, CAPACITY);
    $display("Inserts dropped while full: %0d, remove or peek on empty: %0d, mismatches: %0d.",
             full_drops, empty_hits, mismatches);
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
